FILE: src/yrc_pkg.sv
package yrc_pkg;

    // Largest frame the luma store and the position counters are sized for
    localparam int MAX_WIDTH  = 640;
    localparam int MAX_HEIGHT = 480;

    // Field widths of the stream and configuration payloads
    localparam int W_W = 10;
    localparam int H_W = 9;

    localparam int NPIX_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int POS_W      = $clog2(2 * MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int LUMA_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / 2;
    localparam int LUMA_AW    = $clog2(LUMA_DEPTH);
    localparam int CNT_W      = $clog2(POS_W + 1);

    typedef enum logic [1:0] {
        CFG_PIXEL_FORMAT = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } cfg_index_t;

    typedef enum logic {
        FMT_YUYV = 1'b0,
        FMT_NV12 = 1'b1
    } fmt_t;

    // Where the byte now on the input sits within the frame
    typedef struct packed {
        fmt_t                 fmt;
        logic                 in_range;
        logic                 luma;
        logic                 chroma_first;
        logic                 group_end;
        logic                 last_frame;
        logic                 may_produce;
        logic [1:0]           phase;
        logic [W_W-1:0]       col;
        logic [H_W-1:0]       row;
        logic [LUMA_AW-1:0]   ia;
        logic [W_W-2:0]       half;
        logic [LUMA_AW-1:0]   luma_addr;
        logic                 luma_lane;
    } pos_info_t;

    typedef struct packed {
        logic [7:0]     luma;
        logic [7:0]     cb;
        logic [7:0]     cr;
        logic [W_W-1:0] px;
        logic [H_W-1:0] py;
        logic           lg;
        logic           lf;
    } pix_req_t;

    typedef struct packed {
        logic [7:0]     red;
        logic [7:0]     green;
        logic [7:0]     blue;
        logic [W_W-1:0] px;
        logic [H_W-1:0] py;
        logic           lg;
        logic           lf;
    } pix_res_t;

endpackage

FILE: src/yrc_luma_ram.sv
module yrc_luma_ram (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [yrc_pkg::LUMA_AW-1:0] wr_addr,
    input  logic                        wr_lane,
    input  logic [7:0]                  wr_data,
    input  logic                        rd_en,
    input  logic [yrc_pkg::LUMA_AW-1:0] rd_addr,
    output logic [15:0]                 rd_data
);

    // Even and odd columns in separate lanes: one read returns a horizontal pair
    logic [7:0] even_mem [yrc_pkg::LUMA_DEPTH];
    logic [7:0] odd_mem  [yrc_pkg::LUMA_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en && !wr_lane) begin
            even_mem[wr_addr] <= wr_data;
        end
        if (wr_en && wr_lane) begin
            odd_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= {odd_mem[rd_addr], even_mem[rd_addr]};
        end
    end

endmodule

FILE: src/yrc_pos_track.sv
module yrc_pos_track (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    input  logic [1:0]              cfg_index,
    input  logic [9:0]              cfg_data,
    input  logic                    step,
    input  logic                    frame_start,
    output logic                    busy,
    output yrc_pkg::pos_info_t      info
);

    typedef enum logic [2:0] {
        TR_GEOM,
        TR_MUL,
        TR_TOT,
        TR_DIV,
        TR_ADDR,
        TR_RUN
    } tr_state_t;

    localparam int W_W     = yrc_pkg::W_W;
    localparam int H_W     = yrc_pkg::H_W;
    localparam int NPIX_W  = yrc_pkg::NPIX_W;
    localparam int POS_W   = yrc_pkg::POS_W;
    localparam int LUMA_AW = yrc_pkg::LUMA_AW;
    localparam int CNT_W   = yrc_pkg::CNT_W;

    function automatic logic [W_W-1:0] width_in_use(input logic [W_W-1:0] v);
        logic [W_W-1:0] r;
        begin
            r = v;
            if (v < W_W'(2)) r = W_W'(2);
            else if (v > W_W'(yrc_pkg::MAX_WIDTH)) r = W_W'(yrc_pkg::MAX_WIDTH);
            width_in_use = {r[W_W-1:1], 1'b0};
        end
    endfunction

    function automatic logic [H_W-1:0] height_in_use(input logic [H_W-1:0] v);
        logic [H_W-1:0] r;
        begin
            r = v;
            if (v < H_W'(2)) r = H_W'(2);
            else if (v > H_W'(yrc_pkg::MAX_HEIGHT)) r = H_W'(yrc_pkg::MAX_HEIGHT);
            height_in_use = {r[H_W-1:1], 1'b0};
        end
    endfunction

    tr_state_t              state_reg, state_next;
    yrc_pkg::fmt_t          fmt_reg, fmt_next;
    logic [W_W-1:0]         fw_reg, fw_next;
    logic [H_W-1:0]         fh_reg, fh_next;
    logic [W_W-1:0]         w_reg, w_next;
    logic [H_W-1:0]         h_reg, h_next;
    logic [NPIX_W-1:0]      npix_reg, npix_next;
    logic [POS_W-1:0]       total_reg, total_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [W_W-1:0]         col_reg, col_next;
    logic [H_W-1:0]         row_reg, row_next;
    logic [LUMA_AW-1:0]     ia_reg, ia_next;
    logic [POS_W-1:0]       dvd_reg, dvd_next;
    logic [W_W-1:0]         rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [POS_W-1:0]       pos_e;
    logic [W_W-1:0]         col_e;
    logic [H_W-1:0]         row_e;
    logic [LUMA_AW-1:0]     ia_e;
    logic [W_W-2:0]         half;
    logic                   is_nv12;
    logic                   in_range, luma, group_end;
    logic                   reg_in_range, reg_luma;
    logic                   wrap;
    logic [W_W:0]           trial;
    logic [POS_W-1:0]       diff;
    logic [H_W-1:0]         row_n;
    logic [NPIX_W-1:0]      addr_full;

    assign is_nv12 = (fmt_reg == yrc_pkg::FMT_NV12);
    assign half    = w_reg[W_W-1:1];

    // A frame start restarts the counters for this very byte
    assign pos_e = frame_start ? '0 : pos_reg;
    assign col_e = frame_start ? '0 : col_reg;
    assign row_e = frame_start ? '0 : row_reg;
    assign ia_e  = frame_start ? '0 : ia_reg;

    assign in_range  = (pos_e < total_reg);
    assign luma      = is_nv12 && (pos_e < POS_W'(npix_reg));
    assign group_end = in_range && (is_nv12 ? (!luma && pos_e[0]) : (pos_e[1:0] == 2'b11));

    assign reg_in_range = (pos_reg < total_reg);
    assign reg_luma     = is_nv12 && (pos_reg < POS_W'(npix_reg));

    assign wrap = ({1'b0, col_e} + (W_W+1)'(2)) >= {1'b0, w_reg};

    assign trial = {rem_reg, dvd_reg[POS_W-1]};
    assign diff  = pos_reg - POS_W'(npix_reg);
    assign row_n = is_nv12 ? {dvd_reg[H_W-2:0], 1'b0} : dvd_reg[H_W-1:0];
    assign addr_full = NPIX_W'(row_n) * NPIX_W'(w_reg) + NPIX_W'(rem_reg);

    always_comb begin
        info.fmt          = fmt_reg;
        info.in_range     = in_range;
        info.luma         = luma;
        info.chroma_first = in_range && is_nv12 && !luma && !pos_e[0];
        info.group_end    = group_end;
        info.last_frame   = ((pos_e + POS_W'(1)) == total_reg);
        info.may_produce  = reg_in_range &&
                            (is_nv12 ? (!reg_luma && pos_reg[0]) : (pos_reg[1:0] == 2'b11));
        info.phase        = pos_e[1:0];
        info.col          = col_e;
        info.row          = row_e;
        info.ia           = ia_e;
        info.half         = half;
        info.luma_addr    = pos_e[LUMA_AW:1];
        info.luma_lane    = pos_e[0];
    end

    assign busy = (state_reg != TR_RUN);

    always_comb begin
        state_next = state_reg;
        fmt_next   = fmt_reg;
        fw_next    = fw_reg;
        fh_next    = fh_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        npix_next  = npix_reg;
        total_next = total_reg;
        pos_next   = pos_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        ia_next    = ia_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;

        case (state_reg)
            TR_GEOM: begin
                w_next     = width_in_use(fw_reg);
                h_next     = height_in_use(fh_reg);
                state_next = TR_MUL;
            end
            TR_MUL: begin
                npix_next  = NPIX_W'(w_reg) * NPIX_W'(h_reg);
                state_next = TR_TOT;
            end
            TR_TOT: begin
                total_next = is_nv12 ? (POS_W'(npix_reg) + POS_W'(npix_reg >> 1))
                                     : {npix_reg, 1'b0};
                // Pixel offset whose column and row are wanted
                if (!is_nv12) begin
                    dvd_next = {pos_reg[POS_W-1:2], 1'b0};
                end else if (pos_reg >= POS_W'(npix_reg)) begin
                    dvd_next = {diff[POS_W-1:1], 1'b0};
                end else begin
                    dvd_next = '0;
                end
                rem_next   = '0;
                cnt_next   = '0;
                state_next = TR_DIV;
            end
            TR_DIV: begin
                // Restoring division by the width, one quotient bit a cycle
                if (trial >= {1'b0, w_reg}) begin
                    rem_next = W_W'(trial - {1'b0, w_reg});
                    dvd_next = {dvd_reg[POS_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[W_W-1:0];
                    dvd_next = {dvd_reg[POS_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(POS_W - 1)) begin
                    state_next = TR_ADDR;
                end
            end
            TR_ADDR: begin
                col_next   = rem_reg;
                row_next   = row_n;
                ia_next    = addr_full[NPIX_W-1:1];
                state_next = TR_RUN;
            end
            TR_RUN: begin
                if (step && in_range) begin
                    pos_next = pos_e + POS_W'(1);
                    col_next = col_e;
                    row_next = row_e;
                    ia_next  = ia_e;
                    if (group_end) begin
                        if (wrap) begin
                            col_next = '0;
                            row_next = row_e + (is_nv12 ? H_W'(2) : H_W'(1));
                            ia_next  = ia_e + LUMA_AW'(1) + LUMA_AW'(half);
                        end else begin
                            col_next = col_e + W_W'(2);
                            ia_next  = ia_e + LUMA_AW'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = TR_GEOM;
            end
        endcase

        // Any register write reruns the geometry and position sums
        if (cfg_valid) begin
            case (cfg_index)
                yrc_pkg::CFG_PIXEL_FORMAT: fmt_next = yrc_pkg::fmt_t'(cfg_data[0]);
                yrc_pkg::CFG_FRAME_WIDTH:  fw_next  = cfg_data;
                yrc_pkg::CFG_FRAME_HEIGHT: fh_next  = cfg_data[H_W-1:0];
                default: ;
            endcase
            state_next = TR_GEOM;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TR_GEOM;
            fmt_reg   <= yrc_pkg::FMT_YUYV;
            fw_reg    <= W_W'(yrc_pkg::MAX_WIDTH);
            fh_reg    <= H_W'(yrc_pkg::MAX_HEIGHT);
            w_reg     <= '0;
            h_reg     <= '0;
            npix_reg  <= '0;
            total_reg <= '0;
            pos_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            ia_reg    <= '0;
            dvd_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            fmt_reg   <= fmt_next;
            fw_reg    <= fw_next;
            fh_reg    <= fh_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            npix_reg  <= npix_next;
            total_reg <= total_next;
            pos_reg   <= pos_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            ia_reg    <= ia_next;
            dvd_reg   <= dvd_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: src/yrc_pix_math.sv
module yrc_pix_math (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    output logic                req_ready,
    input  yrc_pkg::pix_req_t   req,
    output logic                res_valid,
    input  logic                res_ready,
    output yrc_pkg::pix_res_t   res
);

    function automatic logic signed [19:0] sx(input logic signed [9:0] a);
        sx = {{10{a[9]}}, a};
    endfunction

    // Round-down by 256, then saturate to a byte
    function automatic logic [7:0] sat(input logic signed [19:0] t);
        if (t[19]) sat = 8'h00;
        else if (t[18:16] != 3'b000) sat = 8'hFF;
        else sat = t[15:8];
    endfunction

    logic signed [9:0]  c_s, d_s, e_s;
    logic signed [19:0] m298_reg, m409_reg, m100_reg, m208_reg, m516_reg;
    logic signed [19:0] r_sum, g_sum, b_sum;
    logic [yrc_pkg::W_W-1:0] p1_x_reg;
    logic [yrc_pkg::H_W-1:0] p1_y_reg;
    logic               p1_lg_reg, p1_lf_reg;
    logic               p1_valid_reg;
    logic               p2_ready;

    assign c_s = $signed({2'b00, req.luma}) - 10'sd16;
    assign d_s = $signed({2'b00, req.cb}) - 10'sd128;
    assign e_s = $signed({2'b00, req.cr}) - 10'sd128;

    assign p2_ready  = !res_valid || res_ready;
    assign req_ready = !p1_valid_reg || p2_ready;

    assign r_sum = m298_reg + m409_reg + 20'sd128;
    assign g_sum = m298_reg - m100_reg - m208_reg + 20'sd128;
    assign b_sum = m298_reg + m516_reg + 20'sd128;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            res_valid    <= 1'b0;
        end else begin
            if (req_ready) begin
                p1_valid_reg <= req_valid;
            end
            if (p2_ready) begin
                res_valid <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_ready && req_valid) begin
            m298_reg <= sx(c_s) * 20'sd298;
            m409_reg <= sx(e_s) * 20'sd409;
            m100_reg <= sx(d_s) * 20'sd100;
            m208_reg <= sx(e_s) * 20'sd208;
            m516_reg <= sx(d_s) * 20'sd516;
            p1_x_reg  <= req.px;
            p1_y_reg  <= req.py;
            p1_lg_reg <= req.lg;
            p1_lf_reg <= req.lf;
        end
        if (p2_ready && p1_valid_reg) begin
            res.red   <= sat(r_sum);
            res.green <= sat(g_sum);
            res.blue  <= sat(b_sum);
            res.px    <= p1_x_reg;
            res.py    <= p1_y_reg;
            res.lg    <= p1_lg_reg;
            res.lf    <= p1_lf_reg;
        end
    end

endmodule

FILE: src/yuv_to_rgb_pixel_converter_unit.sv
// Path: a group-closing byte loads the job slot; each pixel then passes the product and output registers to m_tvalid.
// Throughput: one pixel per cycle out while m_tready is high; a group-closing byte waits for the pixel job slot,
//   so YUYV runs at one byte per cycle and NV12 chroma bytes wait while the slot hands out four pixels a pair.
// Reset: registers return to YUYV, 640 x 480; s_tready stays low while the
//   position sequencer reruns (the same after every configuration write). Luma store is not cleared.
module yuv_to_rgb_pixel_converter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] raw_byte
    input  logic        s_tuser,   // [0] frame_start
    // Output pixel stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                   // [33:24] pixel_x, [42:34] pixel_y, [47:43] zero
    output logic        m_tlast,   // last_of_group
    output logic        m_tuser,   // [0] last_of_frame
    // Register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam int W_W     = yrc_pkg::W_W;
    localparam int H_W     = yrc_pkg::H_W;
    localparam int LUMA_AW = yrc_pkg::LUMA_AW;

    yrc_pkg::pos_info_t info;
    yrc_pkg::pix_req_t  disp_req;
    yrc_pkg::pix_res_t  res;

    logic               trk_busy;
    logic               s_accept;
    logic               is_nv12;

    // Bytes held until their group closes
    logic [7:0]         held_first_reg, held_second_reg, held_third_reg;

    // Pixel job slot: one group of two (YUYV) or four (NV12) pixels
    logic               job_valid_reg;
    logic               job_nv12_reg;
    logic [1:0]         job_idx_reg;
    logic [7:0]         job_ya_reg, job_yb_reg, job_u_reg, job_v_reg;
    logic [W_W-1:0]     job_x_reg;
    logic [H_W-1:0]     job_y_reg;
    logic               job_lf_reg;
    logic               job_last;
    logic               disp_ready;
    logic               disp_fire;
    logic               job_release;
    logic               job_load;

    // Luma rows for the NV12 job
    logic [15:0]        ram_rdata;
    logic [15:0]        row0_reg, row1_reg;
    logic               lum_pend_reg;
    logic               ram_wr_en, ram_rd_en;
    logic [LUMA_AW-1:0] ram_rd_addr;

    assign cfg_ready = 1'b1;
    assign is_nv12   = (info.fmt == yrc_pkg::FMT_NV12);
    assign s_accept  = s_tvalid && s_tready;

    // Position, geometry and config registers; reruns its sums after each write
    yrc_pos_track u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (s_accept),
        .frame_start (s_tuser),
        .busy        (trk_busy),
        .info        (info)
    );

    // Take a byte unless the sequencer is busy or a closing byte finds the job slot occupied.
    // The check uses the stored position only, so a frame start may wait one job longer.
    assign job_last    = job_nv12_reg ? (job_idx_reg == 2'd3) : (job_idx_reg == 2'd1);
    assign disp_fire   = job_valid_reg && disp_ready;
    assign job_release = disp_fire && job_last;
    assign s_tready    = !trk_busy && (!job_valid_reg || job_release || !info.may_produce);
    assign job_load    = s_accept && info.group_end;

    // NV12 luma plane is written; chroma bytes read the two luma rows they cover:
    // the top row with U, the bottom row with V
    assign ram_wr_en   = s_accept && info.luma;
    assign ram_rd_en   = s_accept && info.in_range && is_nv12 && !info.luma;
    assign ram_rd_addr = info.chroma_first ? info.ia : (info.ia + LUMA_AW'(info.half));

    yrc_luma_ram u_luma (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (info.luma_addr),
        .wr_lane (info.luma_lane),
        .wr_data (s_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rdata)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            job_idx_reg   <= 2'd0;
            lum_pend_reg  <= 1'b0;
        end else begin
            if (disp_fire) begin
                job_idx_reg <= job_idx_reg + 2'd1;
                if (job_last) begin
                    job_valid_reg <= 1'b0;
                end
            end
            if (job_load) begin
                job_valid_reg <= 1'b1;
                job_idx_reg   <= 2'd0;
            end
            lum_pend_reg <= job_load && is_nv12;
        end
    end

    // Held bytes: clear on reset, capture in-frame YUYV bytes by phase and the NV12 U byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_first_reg  <= 8'd0;
            held_second_reg <= 8'd0;
            held_third_reg  <= 8'd0;
        end else if (s_accept && info.in_range) begin
            if (!is_nv12) begin
                case (info.phase)
                    2'd0:    held_first_reg  <= s_tdata;
                    2'd1:    held_second_reg <= s_tdata;
                    2'd2:    held_third_reg  <= s_tdata;
                    default: ;
                endcase
            end else if (info.chroma_first) begin
                held_first_reg <= s_tdata;
            end
        end
    end

    // Payload: job contents and luma rows
    always_ff @(posedge aclk) begin
        if (job_load) begin
            job_nv12_reg <= is_nv12;
            job_ya_reg   <= held_first_reg;
            job_yb_reg   <= held_third_reg;
            job_u_reg    <= is_nv12 ? held_first_reg : held_second_reg;
            job_v_reg    <= s_tdata;
            job_x_reg    <= info.col;
            job_y_reg    <= info.row;
            job_lf_reg   <= info.last_frame;
            // Top row came back from the read issued with U
            row0_reg     <= ram_rdata;
        end
        // The bottom row is the registered read result for the V request; lum_pend_reg takes it before the next U read
        if (lum_pend_reg) begin
            row1_reg <= ram_rdata;
        end
    end

    // Hand the job out one pixel a cycle while the colour math takes it
    always_comb begin
        if (job_nv12_reg) begin
            case (job_idx_reg)
                2'd0:    disp_req.luma = row0_reg[7:0];
                2'd1:    disp_req.luma = row0_reg[15:8];
                2'd2:    disp_req.luma = row1_reg[7:0];
                default: disp_req.luma = row1_reg[15:8];
            endcase
        end else begin
            disp_req.luma = job_idx_reg[0] ? job_yb_reg : job_ya_reg;
        end
        disp_req.cb = job_u_reg;
        disp_req.cr = job_v_reg;
        disp_req.px = job_x_reg + W_W'(job_idx_reg[0]);
        disp_req.py = job_y_reg + H_W'(job_nv12_reg & job_idx_reg[1]);
        disp_req.lg = job_last;
        disp_req.lf = job_last && job_lf_reg;
    end

    // Colour matrix, clamp and output register
    yrc_pix_math u_math (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (job_valid_reg),
        .req_ready (disp_ready),
        .req       (disp_req),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {5'b00000, res.py, res.px, res.blue, res.green, res.red};
    assign m_tlast = res.lg;
    assign m_tuser = res.lf;

endmodule
